>>> rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths, defaults and the command/status types that link the sieve
// controller to its datapath.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int IDX_W   = 10;
    localparam int PRIME_W = 13;
    localparam int TOTAL_W = 11;
    localparam int BOUND_W = 13;

    localparam logic [BOUND_W-1:0] BOUND_RESET = 13'd4096;

    localparam int DEF_MAX_BOUND   = 4096;
    localparam int DEF_PRIME_SLOTS = 1024;

    typedef struct packed {
        logic cap_idx;
        logic clr_init;
        logic clr_step;
        logic out_init;
        logic out_adv;
        logic map_rd;
        logic inn_init;
        logic inn_step;
        logic pk_init;
        logic pk_step;
        logic lst_rd;
        logic load_out;
    } pst_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sq_gt;
        logic map_zero;
        logic inn_end;
        logic pk_end;
    } pst_status_t;

endpackage

>>> rtl/pst_ifs.sv
// ----------------------------------------------------------------------------
// pst_ifs
// Query and result channels of the prime table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pst_query_if
    import pst_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] prime_index;

    modport source (output valid, output prime_index, input ready);
    modport sink   (input valid, input prime_index, output ready);
endinterface

interface pst_result_if
    import pst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PRIME_W-1:0] prime_value;
    logic               out_of_range;
    logic [TOTAL_W-1:0] prime_total;

    modport source (output valid, output prime_value, output out_of_range,
                    output prime_total, input ready);
    modport sink   (input valid, input prime_value, input out_of_range,
                    input prime_total, output ready);
endinterface

>>> rtl/prime_sieve_table.sv
// ----------------------------------------------------------------------------
// prime_sieve_table
// Prime lookup table filled by a sieve of Eratosthenes on the first query
// after reset or after a bound write; each query returns one prime by index.
// ----------------------------------------------------------------------------
// Lookup: index captured on the query, list read in S_LOOK, result loaded in
//   S_RESP; a new query waits for that load, and the result register frees
//   the input side while a result waits. First query after reset or a bound
//   write adds the sieve: clear 0..b, cross out multiples of each unmarked
//   i with i*i <= b, pack; b the saturated bound; all on one bit-map port.
// Reset: bound 4096, sieve not done, no result pending; memories not cleared.
module prime_sieve_table
    import pst_pkg::*;
#(
    parameter int MAX_BOUND   = DEF_MAX_BOUND,
    parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    pst_query_if.sink          query,
    pst_result_if.source       result,
    input  logic               cfg_we,
    input  logic [BOUND_W-1:0] cfg_wdata
);

    pst_cmd_t    cmd;
    pst_status_t st;

    pst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .st        (st),
        .cmd       (cmd)
    );

    pst_dpath #(
        .MAX_BOUND   (MAX_BOUND),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .prime_index  (query.prime_index),
        .cmd          (cmd),
        .st           (st),
        .prime_value  (result.prime_value),
        .out_of_range (result.out_of_range),
        .prime_total  (result.prime_total)
    );

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.out_of_range |-> result.prime_value == '0)
        else $error("out-of-range result carries a nonzero prime");

    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.out_of_range |-> result.prime_value >= PRIME_W'(2))
        else $error("in-range result below two");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> !query.ready)
        else $error("query taken while previous one is in flight");

endmodule

>>> rtl/pst_dpath.sv
// ----------------------------------------------------------------------------
// pst_dpath
// Sieve datapath: bound register, composite bit map, prime list, loop
// counters and the result register.
// ----------------------------------------------------------------------------
module pst_dpath
    import pst_pkg::*;
#(
    parameter int MAX_BOUND   = DEF_MAX_BOUND,
    parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [BOUND_W-1:0] cfg_wdata,
    input  logic [IDX_W-1:0]   prime_index,
    input  pst_cmd_t           cmd,
    output pst_status_t        st,
    output logic [PRIME_W-1:0] prime_value,
    output logic               out_of_range,
    output logic [TOTAL_W-1:0] prime_total
);

    localparam int MW  = $clog2(MAX_BOUND + 1);
    localparam int IW  = MW + 1;
    localparam int SQW = MW + 2;
    localparam int CW  = (MW > BOUND_W) ? MW : BOUND_W;
    localparam int SCW = $clog2(PRIME_SLOTS + 1);
    localparam int SAW = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
    localparam int PXW = (IW > PRIME_W) ? IW : PRIME_W;
    localparam int LW  = (IDX_W > SCW) ? IDX_W : SCW;
    localparam int TW  = (SCW > TOTAL_W) ? SCW : TOTAL_W;
    localparam int AXW = (IDX_W > SAW) ? IDX_W : SAW;

    logic [BOUND_W-1:0] bound_reg;
    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      m_reg;
    logic [SQW-1:0]     sq_reg;
    logic [SCW-1:0]     count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               map_bit_reg;
    logic [PRIME_W-1:0] list_rd_reg;
    logic [PRIME_W-1:0] value_reg;
    logic               oor_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               map_mem [MAX_BOUND+1];
    logic [PRIME_W-1:0] list_mem [PRIME_SLOTS];

    logic [CW-1:0]      cfg_x;
    logic [CW-1:0]      bnd_x;
    logic [MW-1:0]      bound;
    logic [PXW-1:0]     i_x;
    logic [AXW-1:0]     idx_ax;
    logic [LW-1:0]      idx_lx;
    logic [LW-1:0]      cnt_lx;
    logic [TW-1:0]      cnt_tx;
    logic               in_rng;
    logic               room;

    assign cfg_x  = CW'(bound_reg);
    assign bnd_x  = (cfg_x > CW'(MAX_BOUND)) ? CW'(MAX_BOUND) : cfg_x;
    assign bound  = bnd_x[MW-1:0];
    assign i_x    = PXW'(i_reg);
    assign idx_ax = AXW'(idx_reg);
    assign idx_lx = LW'(idx_reg);
    assign cnt_lx = LW'(count_reg);
    assign cnt_tx = TW'(count_reg);
    assign in_rng = (idx_lx < cnt_lx) && (idx_lx < LW'(PRIME_SLOTS));
    assign room   = count_reg < SCW'(PRIME_SLOTS);

    assign st.clr_last = (i_reg == IW'(bound));
    assign st.sq_gt    = (sq_reg > SQW'(bound));
    assign st.map_zero = ~map_bit_reg;
    assign st.inn_end  = (m_reg > IW'(bound));
    assign st.pk_end   = (i_reg > IW'(bound));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= BOUND_RESET;
        end
        else if (cfg_we)
        begin
            bound_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_idx)
        begin
            idx_reg <= prime_index;
        end

        if (cmd.clr_init)
        begin
            i_reg <= '0;
        end
        else if (cmd.out_init || cmd.pk_init)
        begin
            i_reg <= IW'(2);
        end
        else if (cmd.clr_step || cmd.out_adv || cmd.pk_step)
        begin
            i_reg <= i_reg + IW'(1);
        end

        if (cmd.out_init)
        begin
            sq_reg <= SQW'(4);
        end
        else if (cmd.out_adv)
        begin
            sq_reg <= sq_reg + SQW'({i_reg, 1'b1});
        end

        if (cmd.inn_init)
        begin
            m_reg <= i_reg + i_reg;
        end
        else if (cmd.inn_step)
        begin
            m_reg <= m_reg + i_reg;
        end

        if (cmd.pk_init)
        begin
            count_reg <= '0;
        end
        else if (cmd.pk_step && st.map_zero && room)
        begin
            count_reg <= count_reg + SCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            map_mem[i_reg[MW-1:0]] <= 1'b0;
        end
        else if (cmd.inn_step)
        begin
            map_mem[m_reg[MW-1:0]] <= 1'b1;
        end

        if (cmd.map_rd)
        begin
            map_bit_reg <= map_mem[i_reg[MW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pk_step && st.map_zero && room)
        begin
            list_mem[count_reg[SAW-1:0]] <= i_x[PRIME_W-1:0];
        end

        if (cmd.lst_rd)
        begin
            list_rd_reg <= list_mem[idx_ax[SAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_reg <= in_rng ? list_rd_reg : '0;
            oor_reg   <= ~in_rng;
            total_reg <= cnt_tx[TOTAL_W-1:0];
        end
    end

    assign prime_value  = value_reg;
    assign out_of_range = oor_reg;
    assign prime_total  = total_reg;

endmodule

>>> rtl/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer for the sieve: clear, cross out, pack, then table lookups.
// Owns the handshakes and the sieve-done flag.
// ----------------------------------------------------------------------------
module pst_ctrl
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  pst_status_t st,
    output pst_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_OCHK,
        S_OWAIT,
        S_INNER,
        S_PRD,
        S_PWR,
        S_LOOK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_idx = 1'b1;
                    if (done_reg)
                    begin
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_OCHK;
                end
            end
            S_OCHK:
            begin
                if (st.sq_gt)
                begin
                    cmd.pk_init = 1'b1;
                    state_next  = S_PRD;
                end
                else
                begin
                    cmd.map_rd = 1'b1;
                    state_next = S_OWAIT;
                end
            end
            S_OWAIT:
            begin
                if (st.map_zero)
                begin
                    cmd.inn_init = 1'b1;
                    state_next   = S_INNER;
                end
                else
                begin
                    cmd.out_adv = 1'b1;
                    state_next  = S_OCHK;
                end
            end
            S_INNER:
            begin
                if (st.inn_end)
                begin
                    cmd.out_adv = 1'b1;
                    state_next  = S_OCHK;
                end
                else
                begin
                    cmd.inn_step = 1'b1;
                end
            end
            S_PRD:
            begin
                if (st.pk_end)
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    cmd.map_rd = 1'b1;
                    state_next = S_PWR;
                end
            end
            S_PWR:
            begin
                cmd.pk_step = 1'b1;
                state_next  = S_PRD;
            end
            S_LOOK:
            begin
                cmd.lst_rd = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                done_reg <= 1'b0;
            end
            else if (state_reg == S_PRD && st.pk_end)
            begin
                done_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> test/prime_sieve_table_tb.sv
// ----------------------------------------------------------------------------
// prime_sieve_table_tb
// Self-checking bench for the sieve-built prime lookup table. A queue-fed
// driver sends index queries with random gaps. The result side stalls at
// random; gaps and stalls stop in the last phase. Each query transaction is
// predicted by a local sieve over the current bound, and each result is
// checked field by field in order. The bound is rewritten between phases,
// covering 0, 1, tiny values, the maximum and saturating values, then random
// bounds with mostly in-range indexes.
module prime_sieve_table_tb;
    import pst_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RAND_PHASES  = 10;
    localparam int RAND_ITEMS   = 190;
    localparam int MAX_GAP      = 14;

    typedef struct packed {
        logic [PRIME_W-1:0] value;
        logic               oor;
        logic [TOTAL_W-1:0] total;
    } lookup_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [BOUND_W-1:0] cfg_wdata;

    pst_query_if  query_bus ();
    pst_result_if result_bus ();

    prime_sieve_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [BOUND_W-1:0] bound_reg;
    bit                 sieved;
    bit                 composite_marks [0:DEF_MAX_BOUND];
    logic [PRIME_W-1:0] prime_tab [DEF_PRIME_SLOTS];
    int unsigned        prime_cnt;

    logic [IDX_W-1:0]   pending_indexes [$];
    lookup_t            expected_lookups [$];
    bit                 query_accepted;
    bit                 steady;
    int                 query_gap;
    int                 stall_left;
    int                 fail_count;
    int                 cycle_count;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void queue_index(input logic [IDX_W-1:0] v);
        pending_indexes.insert(pending_indexes.size(), v);
    endfunction

    function automatic void sieve_primes();
        int eff;
        int i;
        int m;
        eff = (bound_reg > DEF_MAX_BOUND) ? DEF_MAX_BOUND : int'(bound_reg);
        for (i = 0; i <= eff; i++)
            composite_marks[i] = 1'b0;
        for (i = 2; i * i <= eff; i++)
            if (!composite_marks[i])
                for (m = i + i; m <= eff; m += i)
                    composite_marks[m] = 1'b1;
        prime_cnt = 0;
        for (i = 2; i <= eff; i++)
        begin
            if (!composite_marks[i] && prime_cnt < DEF_PRIME_SLOTS)
            begin
                prime_tab[prime_cnt] = PRIME_W'(i);
                prime_cnt++;
            end
        end
        sieved = 1'b1;
    endfunction

    function automatic lookup_t predict_lookup(input logic [IDX_W-1:0] idx);
        lookup_t res;
        if (!sieved)
            sieve_primes();
        if (idx < prime_cnt)
        begin
            res.value = prime_tab[idx];
            res.oor   = 1'b0;
        end
        else
        begin
            res.value = '0;
            res.oor   = 1'b1;
        end
        res.total = TOTAL_W'(prime_cnt);
        return res;
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (pending_indexes.size() != 0 || query_bus.valid
               || expected_lookups.size() != 0);
    endtask

    task automatic set_bound(input int unsigned v);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= BOUND_W'(v);
        bound_reg  = BOUND_W'(v);
        sieved     = 1'b0;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // query driver
    always @(negedge clk)
    begin : query_driver
        logic             nxt_valid;
        logic [IDX_W-1:0] nxt_idx;
        nxt_valid = query_bus.valid;
        nxt_idx   = query_bus.prime_index;
        if (rst_n)
        begin
            if (query_accepted)
            begin
                nxt_valid      = 1'b0;
                query_accepted = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (query_gap > 0)
                    query_gap--;
                else if (pending_indexes.size() != 0)
                begin
                    if (!steady && $urandom_range(0, 5) == 0)
                        query_gap = $urandom_range(1, MAX_GAP) - 1;
                    else
                    begin
                        nxt_valid = 1'b1;
                        nxt_idx   = pending_indexes.pop_front();
                    end
                end
            end
        end
        query_bus.valid       <= nxt_valid;
        query_bus.prime_index <= nxt_idx;
    end

    // result stall
    always @(negedge clk)
    begin : result_stall
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (rst_n && !steady)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, MAX_GAP) - 1;
                nxt_ready  = 1'b0;
            end
        end
        result_bus.ready <= nxt_ready;
    end

    // monitor and checker
    always @(posedge clk)
    begin : lookup_monitor
        lookup_t want;
        if (rst_n)
        begin
            if (query_bus.valid && query_bus.ready)
            begin
                expected_lookups.insert(expected_lookups.size(),
                                        predict_lookup(query_bus.prime_index));
                query_accepted = 1'b1;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $error("result transaction with no query outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (result_bus.prime_value !== want.value)
                    begin
                        $error("prime_value: expected %0d, got %0d",
                               want.value, result_bus.prime_value);
                        fail_count++;
                    end
                    if (result_bus.out_of_range !== want.oor)
                    begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.oor, result_bus.out_of_range);
                        fail_count++;
                    end
                    if (result_bus.prime_total !== want.total)
                    begin
                        $error("prime_total: expected %0d, got %0d",
                               want.total, result_bus.prime_total);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("prime_sieve_table regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int          p;
        int          n;
        int unsigned next_bound;
        int unsigned pick;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        query_bus.valid       = 1'b0;
        query_bus.prime_index = '0;
        result_bus.ready      = 1'b0;
        bound_reg             = BOUND_RESET;
        sieved                = 1'b0;
        prime_cnt             = 0;
        query_accepted        = 1'b0;
        steady                = 1'b0;
        query_gap             = 0;
        stall_left            = 0;
        fail_count            = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset bound: first and last primes, first index past the count
        queue_index(10'd0);   queue_index(10'd1);
        queue_index(10'd2);   queue_index(10'd563);
        queue_index(10'd564); queue_index(10'd1023);
        queue_index(10'd511); queue_index(10'd512);

        // no primes at all for bounds 0 and 1, then tiny bounds 2 and 3
        set_bound(0);
        queue_index(10'd0);   queue_index(10'd1023);
        set_bound(1);
        queue_index(10'd0);   queue_index(10'd1);
        set_bound(2);
        queue_index(10'd0);   queue_index(10'd1);
        set_bound(3);
        queue_index(10'd0);   queue_index(10'd1);
        queue_index(10'd2);

        // saturating bounds
        set_bound((1 << BOUND_W) - 1);
        queue_index(10'd563); queue_index(10'd564);
        set_bound(DEF_MAX_BOUND + 1);
        queue_index(10'd0);   queue_index(10'd563);
        queue_index(10'd564);

        for (p = 0; p < RAND_PHASES; p++)
        begin
            if (p == RAND_PHASES - 1)
                next_bound = DEF_MAX_BOUND;
            else if (p % 2)
                next_bound = $urandom_range(0, (1 << BOUND_W) - 1);
            else
                next_bound = $urandom_range(2, DEF_MAX_BOUND);
            set_bound(next_bound);
            if (p == RAND_PHASES - 1)
                steady = 1'b1;
            if (!sieved)
                sieve_primes();
            for (n = 0; n < RAND_ITEMS; n++)
            begin
                pick = $urandom_range(0, 19);
                if (prime_cnt != 0 && pick < 15)
                    queue_index(IDX_W'($urandom_range(0, prime_cnt - 1)));
                else if (pick == 15 && prime_cnt < (1 << IDX_W))
                    queue_index(IDX_W'(prime_cnt));
                else
                    queue_index(IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (expected_lookups.size() != 0)
        begin
            $error("%0d results never arrived", expected_lookups.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("prime_sieve_table regression: pass");
        else
            $display("prime_sieve_table regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/pst_pkg.sv
rtl/pst_ifs.sv
rtl/pst_dpath.sv
rtl/pst_ctrl.sv
rtl/prime_sieve_table.sv
test/prime_sieve_table_tb.sv
